FILE: design/vfcc_pkg.sv
// Package: shared types and codes for the void-filling channel calendar.
package vfcc_pkg;

    localparam int TW = 48;

    typedef enum logic [1:0] {
        REQ_CHECK   = 2'd0,
        REQ_FIND    = 2'd1,
        REQ_RESERVE = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    localparam logic [0:0] CFG_CHANNELS = 1'b0;
    localparam logic [0:0] CFG_MARGIN   = 1'b1;

    typedef struct packed {
        logic [1:0]    req_type;
        logic [3:0]    port_index;
        logic [5:0]    channel_index;
        logic [TW-1:0] window_start;
        logic [TW-1:0] window_end;
        logic [TW-1:0] current_time;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] chosen_channel;
        logic [7:0] reservation_count;
    } rsp_t;

    // controller -> datapath
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,     // latch request, set up slot
        CMD_CNT_RD,   // latch slot count
        CMD_SCAN_RD,  // issue read of entry idx
        CMD_SCAN_EV,  // evaluate entry read data
        CMD_NEXT_CH,  // find: advance channel
        CMD_POS_RD,   // reserve: read entry idx for position
        CMD_POS_EV,
        CMD_SHIFT_RD, // read entry idx-1
        CMD_SHIFT_WR, // write it at idx
        CMD_INSERT,   // write new at pos
        CMD_PR_RD,    // prune: read entry
        CMD_PR_EV,
        CMD_CP_RD,    // copy read idx+drop
        CMD_CP_WR,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic range_err;  // port/channel invalid, or request type NONE
        logic find_op;
        logic reserve_op;
        logic full;
        logic scan_done;  // scan of current slot finished
        logic scan_fit;
        logic last_ch;
        logic pos_done;
        logic shift_done;
        logic prune_skip;
        logic prune_done;
        logic copy_done;
    } sts_t;

endpackage

FILE: design/void_filling_channel_calendar.sv
// Top level: void-filling channel calendar with APB register port.
// Requests are handled one at a time. Check scans a list entry by entry;
// find repeats that per channel; reserve walks for position and shifts
// the tail, then, when the list is at or above the prune threshold, scans
// the ended head and compacts the list. The calendar memory has a single
// read port and needs no clearing after reset: per-slot counts start at
// zero.
module void_filling_channel_calendar #(
    parameter int NUM_PORTS         = 4,
    parameter int CHANNELS_PER_PORT = 8,
    parameter int MAX_RESERVATIONS  = 128,
    parameter int PRUNE_THRESHOLD   = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  vfcc_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output vfcc_pkg::rsp_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);
    logic [3:0]              chan_cfg_reg;
    logic [vfcc_pkg::TW-1:0] margin_reg;
    logic                    busy, done, in_fire;
    vfcc_pkg::cmd_t          cmd;
    vfcc_pkg::sts_t          sts;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg <= 4'd8;
            margin_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3] == vfcc_pkg::CFG_CHANNELS && paddr[2:0] == 3'd0)
                chan_cfg_reg <= pwdata[3:0];
            else if (paddr[3] == vfcc_pkg::CFG_MARGIN && paddr[2:0] == 3'd0)
                margin_reg <= pwdata[vfcc_pkg::TW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[3] == vfcc_pkg::CFG_CHANNELS && paddr[2:0] == 3'd0)
            prdata = {60'd0, chan_cfg_reg};
        else if (paddr[3] == vfcc_pkg::CFG_MARGIN && paddr[2:0] == 3'd0)
            prdata = 64'(margin_reg);
    end

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    assign out_valid = done;

    vfcc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy), .done(done),
        .out_taken(!out_stall), .sts(sts), .cmd(cmd)
    );

    vfcc_datapath #(
        .NUM_PORTS(NUM_PORTS), .CHANNELS_PER_PORT(CHANNELS_PER_PORT),
        .MAX_RESERVATIONS(MAX_RESERVATIONS), .PRUNE_THRESHOLD(PRUNE_THRESHOLD)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(in_data),
        .channels_in_use(chan_cfg_reg), .prune_margin(margin_reg),
        .sts(sts), .rsp(out_data)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == vfcc_pkg::ST_RANGE
        |-> out_data.reservation_count == 8'd0) else $error("range count");
endmodule

FILE: design/vfcc_datapath.sv
// Datapath: request registers, calendar memory, indexes and result.
module vfcc_datapath #(
    parameter int NUM_PORTS         = 4,
    parameter int CHANNELS_PER_PORT = 8,
    parameter int MAX_RESERVATIONS  = 128,
    parameter int PRUNE_THRESHOLD   = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vfcc_pkg::cmd_t         cmd,
    input  vfcc_pkg::req_t         req,
    input  logic [3:0]             channels_in_use,
    input  logic [vfcc_pkg::TW-1:0] prune_margin,
    output vfcc_pkg::sts_t         sts,
    output vfcc_pkg::rsp_t         rsp
);
    localparam int TIME_BITS = vfcc_pkg::TW;
    localparam int SLOTS = (NUM_PORTS + 1) * CHANNELS_PER_PORT;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW    = $clog2(MAX_RESERVATIONS);
    localparam int CW    = EW + 1;
    localparam int CHW   = (CHANNELS_PER_PORT > 1) ? $clog2(CHANNELS_PER_PORT) : 1;
    localparam int AW    = SW + EW;
    localparam int DEPTH = SLOTS * (1 << EW);

    logic [2*TIME_BITS-1:0] mem [DEPTH];
    logic [CW-1:0]          cnt_mem [SLOTS];

    logic [TIME_BITS-1:0] ws_reg, we_reg;
    logic [1:0]           op_reg;
    logic [5:0]           chan_reg;
    logic [CHW-1:0]       ch_reg;
    logic [SW-1:0]        slot_reg;
    logic [CW-1:0]        n_reg, idx_reg, pos_reg, drop_reg;
    logic [2*TIME_BITS-1:0] rd_reg;
    logic                 range_reg;
    logic                 fit_reg, done_reg;
    logic [TIME_BITS-1:0] cutoff_reg;
    logic                 noprune_reg;

    logic [6:0]           nch;
    logic                 port_ok;
    logic [TIME_BITS-1:0] rs, re;
    logic [AW-1:0]        addr;
    logic [CW-1:0]        rd_idx;
    logic [SW-1:0]        slot_base;

    assign rs = rd_reg[2*TIME_BITS-1:TIME_BITS];
    assign re = rd_reg[TIME_BITS-1:0];

    always_comb
    begin
        if ({3'd0, req.port_index} == 7'(NUM_PORTS))
            nch = 7'd1;
        else if (channels_in_use == 4'd0)
            nch = 7'd1;
        else if ({3'd0, channels_in_use} > 7'(CHANNELS_PER_PORT))
            nch = 7'(CHANNELS_PER_PORT);
        else
            nch = {3'd0, channels_in_use};
    end

    assign port_ok   = {28'd0, req.port_index} <= 32'(NUM_PORTS);
    assign slot_base = SW'(32'(req.port_index) * CHANNELS_PER_PORT);

    always_comb
    begin
        case (cmd)
            vfcc_pkg::CMD_SHIFT_RD: rd_idx = idx_reg - CW'(1);
            vfcc_pkg::CMD_CP_RD:    rd_idx = idx_reg + drop_reg;
            default:                rd_idx = idx_reg;
        endcase
    end

    assign addr = {slot_reg, rd_idx[EW-1:0]};

    // memory: one read, one write port
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[addr];
        case (cmd)
            vfcc_pkg::CMD_SHIFT_WR: mem[{slot_reg, idx_reg[EW-1:0]}] <= rd_reg;
            vfcc_pkg::CMD_INSERT:   mem[{slot_reg, pos_reg[EW-1:0]}] <= {ws_reg, we_reg};
            vfcc_pkg::CMD_CP_WR:    mem[{slot_reg, idx_reg[EW-1:0]}] <= rd_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                cnt_mem[i] <= '0;
        end
        else
        begin
            case (cmd)
                vfcc_pkg::CMD_INSERT: cnt_mem[slot_reg] <= n_reg + CW'(1);
                vfcc_pkg::CMD_CP_WR:
                    if (idx_reg + drop_reg + CW'(1) >= n_reg)
                        cnt_mem[slot_reg] <= n_reg - drop_reg;
                vfcc_pkg::CMD_PR_EV:
                    if (!(idx_reg < n_reg && re < cutoff_reg) && idx_reg == n_reg)
                        cnt_mem[slot_reg] <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            vfcc_pkg::CMD_LOAD:
            begin
                ws_reg    <= req.window_start;
                we_reg    <= req.window_end;
                op_reg    <= req.req_type;
                chan_reg  <= req.channel_index;
                ch_reg    <= '0;
                noprune_reg <= prune_margin > req.current_time;
                cutoff_reg  <= req.current_time - prune_margin;
                if (req.req_type == vfcc_pkg::REQ_FIND)
                begin
                    range_reg <= !port_ok;
                    slot_reg  <= slot_base;
                end
                else
                begin
                    range_reg <= req.req_type == vfcc_pkg::REQ_NONE || !port_ok
                                 || {1'b0, req.channel_index} >= nch;
                    slot_reg  <= slot_base + SW'(req.channel_index);
                end
                fit_reg  <= 1'b0;
                done_reg <= 1'b0;
                idx_reg  <= '0;
            end
            vfcc_pkg::CMD_CNT_RD:
            begin
                n_reg    <= cnt_mem[slot_reg];
                idx_reg  <= '0;
                done_reg <= 1'b0;
                // on reserve, fit_reg carries the list-full flag
                fit_reg  <= op_reg == vfcc_pkg::REQ_RESERVE
                            && cnt_mem[slot_reg] >= CW'(MAX_RESERVATIONS);
                drop_reg <= '0;
            end
            vfcc_pkg::CMD_SCAN_EV:
                if (idx_reg >= n_reg)
                begin
                    done_reg <= 1'b1;
                    fit_reg  <= 1'b1;
                end
                else if (we_reg <= rs)
                begin
                    done_reg <= 1'b1;
                    fit_reg  <= 1'b1;
                end
                else if (ws_reg >= re)
                    idx_reg <= idx_reg + CW'(1);
                else
                    done_reg <= 1'b1;
            vfcc_pkg::CMD_NEXT_CH:
            begin
                ch_reg   <= ch_reg + CHW'(1);
                slot_reg <= slot_reg + SW'(1);
            end
            vfcc_pkg::CMD_POS_EV:
                if (idx_reg < n_reg && rs < ws_reg)
                    idx_reg <= idx_reg + CW'(1);
                else
                begin
                    done_reg <= 1'b1;
                    pos_reg  <= idx_reg;
                    idx_reg  <= n_reg;
                end
            vfcc_pkg::CMD_SHIFT_WR: idx_reg <= idx_reg - CW'(1);
            vfcc_pkg::CMD_INSERT:
            begin
                n_reg    <= n_reg + CW'(1);
                idx_reg  <= '0;
                drop_reg <= '0;
                done_reg <= 1'b0;
            end
            vfcc_pkg::CMD_PR_EV:
                if (idx_reg < n_reg && re < cutoff_reg)
                    idx_reg <= idx_reg + CW'(1);
                else
                begin
                    done_reg <= 1'b1;
                    drop_reg <= idx_reg;
                    idx_reg  <= '0;
                end
            vfcc_pkg::CMD_CP_WR: idx_reg <= idx_reg + CW'(1);
            vfcc_pkg::CMD_FINISH: n_reg <= cnt_mem[slot_reg];
            default: ;
        endcase
    end

    logic [6:0] nch_reg;
    always_ff @(posedge clk)
    begin
        if (cmd == vfcc_pkg::CMD_LOAD)
            nch_reg <= nch;
    end

    always_comb
    begin
        sts.range_err  = range_reg;
        sts.find_op    = op_reg == vfcc_pkg::REQ_FIND;
        sts.reserve_op = op_reg == vfcc_pkg::REQ_RESERVE;
        sts.full       = n_reg >= CW'(MAX_RESERVATIONS);
        sts.scan_done  = done_reg;
        sts.scan_fit   = fit_reg;
        sts.last_ch    = 7'(ch_reg) + 7'd1 >= nch_reg;
        sts.pos_done   = done_reg;
        sts.shift_done = idx_reg <= pos_reg;
        sts.prune_skip = n_reg < CW'(PRUNE_THRESHOLD) || noprune_reg;
        sts.prune_done = done_reg;
        sts.copy_done  = idx_reg + drop_reg >= n_reg;
    end

    // result, valid after FINISH has refreshed n_reg
    always_comb
    begin
        rsp.chosen_channel    = chan_reg[2:0];
        rsp.reservation_count = 8'(n_reg);
        if (op_reg == vfcc_pkg::REQ_FIND)
        begin
            if (range_reg || !fit_reg)
            begin
                rsp.status            = range_reg ? vfcc_pkg::ST_RANGE : vfcc_pkg::ST_NOFIT;
                rsp.chosen_channel    = '0;
                rsp.reservation_count = '0;
            end
            else
            begin
                rsp.status         = vfcc_pkg::ST_OK;
                rsp.chosen_channel = 3'(ch_reg);
            end
        end
        else if (range_reg)
        begin
            rsp.status            = vfcc_pkg::ST_RANGE;
            rsp.reservation_count = '0;
        end
        else if (op_reg == vfcc_pkg::REQ_CHECK)
            rsp.status = fit_reg ? vfcc_pkg::ST_OK : vfcc_pkg::ST_NOFIT;
        else if (fit_reg)
            rsp.status = vfcc_pkg::ST_FULL;
        else
            rsp.status = vfcc_pkg::ST_OK;
    end
endmodule

FILE: design/vfcc_ctrl.sv
// Controller: sequences scan, insert and prune steps for each request.
module vfcc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    output logic           busy,
    output logic           done,
    input  logic           out_taken,
    input  vfcc_pkg::sts_t sts,
    output vfcc_pkg::cmd_t cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CNT, S_CHK, S_SC_RD, S_SC_EV, S_SC_NX, S_PS_RD, S_PS_EV,
        S_SH_CHK, S_SH_RD, S_SH_WR, S_INS, S_PR_CHK, S_PR_RD, S_PR_EV,
        S_CP_CHK, S_CP_RD, S_CP_WR, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = vfcc_pkg::CMD_IDLE;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd        = vfcc_pkg::CMD_LOAD;
                    state_next = S_CNT;
                end
            S_CNT:
            begin
                cmd        = vfcc_pkg::CMD_CNT_RD;
                state_next = S_CHK;
            end
            S_CHK:
                if (sts.range_err)
                    state_next = S_FIN;
                else if (sts.reserve_op)
                    state_next = sts.full ? S_FIN : S_PS_RD;
                else
                    state_next = S_SC_RD;
            S_SC_RD:
            begin
                cmd        = vfcc_pkg::CMD_SCAN_RD;
                state_next = S_SC_EV;
            end
            S_SC_EV:
            begin
                cmd        = vfcc_pkg::CMD_SCAN_EV;
                state_next = S_SC_NX;
            end
            S_SC_NX:
                if (!sts.scan_done)
                    state_next = S_SC_RD;
                else if (sts.find_op && !sts.scan_fit && !sts.last_ch)
                begin
                    cmd        = vfcc_pkg::CMD_NEXT_CH;
                    state_next = S_CNT;
                end
                else
                    state_next = S_FIN;
            S_PS_RD:
            begin
                cmd        = vfcc_pkg::CMD_POS_RD;
                state_next = S_PS_EV;
            end
            S_PS_EV:
            begin
                cmd        = vfcc_pkg::CMD_POS_EV;
                state_next = S_SH_CHK;
            end
            S_SH_CHK:
                if (!sts.pos_done)
                    state_next = S_PS_RD;
                else if (sts.shift_done)
                    state_next = S_INS;
                else
                    state_next = S_SH_RD;
            S_SH_RD:
            begin
                cmd        = vfcc_pkg::CMD_SHIFT_RD;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd        = vfcc_pkg::CMD_SHIFT_WR;
                state_next = S_SH_CHK;
            end
            S_INS:
            begin
                cmd        = vfcc_pkg::CMD_INSERT;
                state_next = S_PR_CHK;
            end
            S_PR_CHK:
                state_next = sts.prune_skip ? S_FIN : S_PR_RD;
            S_PR_RD:
            begin
                cmd        = vfcc_pkg::CMD_PR_RD;
                state_next = S_PR_EV;
            end
            S_PR_EV:
            begin
                cmd        = vfcc_pkg::CMD_PR_EV;
                state_next = S_CP_CHK;
            end
            S_CP_CHK:
                if (!sts.prune_done)
                    state_next = S_PR_RD;
                else if (sts.copy_done)
                    state_next = S_FIN;
                else
                    state_next = S_CP_RD;
            S_CP_RD:
            begin
                cmd        = vfcc_pkg::CMD_CP_RD;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                cmd        = vfcc_pkg::CMD_CP_WR;
                state_next = S_CP_CHK;
            end
            S_FIN:
            begin
                cmd        = vfcc_pkg::CMD_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_taken)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_OUT;
endmodule
